[hw/rtl/ctrnn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTRNN package
// Shared widths, opcodes and the piecewise-linear sigmoid.
// ----------------------------------------------------------------------------
package ctrnn_pkg;

  localparam int unsigned QW = 24;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [2:0] op_t;

  localparam op_t OP_STEP   = 3'd0;
  localparam op_t OP_WEIGHT = 3'd1;
  localparam op_t OP_BIAS   = 3'd2;
  localparam op_t OP_STATE  = 3'd3;
  localparam op_t OP_INPUT  = 3'd4;

  localparam logic signed [QW-1:0] QMAX = 24'sh7FFFFF;
  localparam logic signed [QW-1:0] QMIN = -24'sh800000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  source_index;
    logic [4:0]  target_index;
    logic signed [QW-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  neuron_index;
    logic signed [QW-1:0] neuron_state;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic clear;
    logic acc;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [16:0] sigmoid_q16(input logic signed [QW:0] a);
    logic [QW:0] m;
    logic [QW:0] s;
    begin
      m = a[QW] ? (QW+1)'(-a) : (QW+1)'(a);
      if (m >= (QW+1)'(327680)) s = (QW+1)'(65536);
      else if (m >= (QW+1)'(155648)) s = (m >> 5) + (QW+1)'(55296);
      else if (m >= (QW+1)'(65536)) s = (m >> 3) + (QW+1)'(40960);
      else s = (m >> 2) + (QW+1)'(32768);
      if (a[QW]) s = (QW+1)'(65536) - s;
      sigmoid_q16 = s[16:0];
    end
  endfunction

  function automatic q_t sat24(input logic signed [47:0] v);
    begin
      if (v > 48'(signed'(QMAX))) sat24 = QMAX;
      else if (v < 48'(signed'(QMIN))) sat24 = QMIN;
      else sat24 = v[QW-1:0];
    end
  endfunction

endpackage

[hw/rtl/ctrnn_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTRNN stream interface
// Valid/ready channel that carries one payload.
// ----------------------------------------------------------------------------
interface ctrnn_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/ctrnn_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTRNN cell
// Holds one neuron's weight column and accumulator; the sigmoid value passes
// along.
// ----------------------------------------------------------------------------
module ctrnn_cell #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrnn_pkg::cell_ctrl_t   ctrl_i,
  input  logic                    w_we_i,
  input  logic [AW-1:0]           w_addr_i,
  input  logic signed [23:0]      w_data_i,
  input  logic                    w_rd_i,
  input  logic [AW-1:0]           w_raddr_i,
  input  logic signed [17:0]      sig_i,
  output logic signed [17:0]      sig_o,
  output logic signed [47:0]      acc_o
);
  import ctrnn_pkg::*;

  q_t wmem [DEPTH];
  q_t w_q;
  logic signed [17:0] sig_q;
  logic signed [47:0] acc_q;
  logic signed [47:0] prod;

  assign prod  = 48'(w_q) * 48'(sig_q);
  assign sig_o = sig_q;
  assign acc_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (w_we_i) wmem[w_addr_i] <= w_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= '0;
      sig_q <= '0;
      acc_q <= '0;
    end else begin
      w_q <= w_rd_i ? wmem[w_raddr_i] : '0;
      if (ctrl_i.shift) sig_q <= sig_i;
      if (ctrl_i.clear) acc_q <= '0;
      else if (ctrl_i.acc) acc_q <= acc_q + prod;
    end
  end
endmodule

[hw/rtl/ctrnn_euler_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTRNN Euler step
// Channel  Dir  Payload
// in_if    in   opcode, source_index, target_index, write_value
// out_if   out  neuron_index, neuron_state, last_of_run
// cfg      in   step_rate_we_i / step_rate_i
// During a step the cell chain runs first: each cycle a sigmoid enters the
// chain and every cell adds one product, with each cell reading one entry of
// its own weight column. Then the derivatives are formed (S_DER). After that
// each state is updated (S_UPD) and presented for one output transaction
// (S_OUT), which output stalls can hold. Reset clears states and external
// inputs and sets step_rate to 655.
// ----------------------------------------------------------------------------
module ctrnn_euler_step #(
  parameter int unsigned NEURONS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_rate_we_i,
  input  logic [23:0] step_rate_i,
  ctrnn_stream_if.sink   in_if,
  ctrnn_stream_if.source out_if
);
  import ctrnn_pkg::*;

  localparam int unsigned NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned CW = $clog2(2*NEURONS + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DER  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] idx_q;
  logic [23:0] rate_q;

  q_t bias_q [NEURONS];
  q_t ext_q [NEURONS];
  q_t y_q [NEURONS];
  q_t der_q [NEURONS];

  cmd_t cmd;
  res_t res_q;
  logic out_valid_q;
  cell_ctrl_t ctrl;

  logic src_ok;
  logic dst_ok;
  logic w_wr;
  logic signed [17:0] sig_chain [NEURONS+1];
  logic signed [47:0] acc [NEURONS];
  logic signed [QW:0] sig_arg;
  logic [NW-1:0] jsel;
  logic signed [47:0] inc_full;
  q_t ny;

  assign cmd = in_if.payload;
  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.payload = res_q;

  assign src_ok = (6'(cmd.source_index) < 6'(NEURONS));
  assign dst_ok = (6'(cmd.target_index) < 6'(NEURONS));
  assign w_wr   = (state_q == S_IDLE) && in_if.valid && (cmd.opcode == OP_WEIGHT)
                  && src_ok && dst_ok;

  // The source index feeding the chain this cycle; the chain is loaded in source
  // order, with cell i taking weight row j delayed by its position.
  assign jsel = cnt_q[NW-1:0];
  assign sig_arg = (QW+1)'(y_q[jsel]) + (QW+1)'(bias_q[jsel]);
  assign sig_chain[0] = (cnt_q < CW'(NEURONS)) ? 18'(signed'({1'b0, sigmoid_q16(sig_arg)}))
                                               : 18'sd0;

  always_comb begin
    ctrl.clear = (state_q == S_IDLE);
    ctrl.shift = (state_q == S_MAC);
    ctrl.acc   = (state_q == S_MAC);
  end

  for (genvar i = 0; i < NEURONS; i++) begin : g_cell
    logic [CW-1:0] off;
    logic rd;
    logic we;
    // The offset wraps above NEURONS while the count is still below i.
    assign off = cnt_q - CW'(i);
    assign rd  = (state_q == S_MAC) && (off < CW'(NEURONS));
    assign we  = w_wr && (cmd.target_index == 5'(i));
    ctrnn_cell #(
      .DEPTH(NEURONS),
      .AW   (NW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .w_we_i   (we),
      .w_addr_i (cmd.source_index[NW-1:0]),
      .w_data_i (cmd.write_value),
      .w_rd_i   (rd),
      .w_raddr_i(off[NW-1:0]),
      .sig_i    (sig_chain[i]),
      .sig_o    (sig_chain[i+1]),
      .acc_o    (acc[i])
    );
  end

  assign inc_full = (48'(der_q[idx_q]) * 48'(signed'({1'b0, rate_q}))) >>> 16;
  assign ny = sat24(48'(y_q[idx_q]) + inc_full);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_if.valid && cmd.opcode == OP_STEP) state_d = S_MAC;
      S_MAC:  if (cnt_q == CW'(2*NEURONS)) state_d = S_DER;
      S_DER:  state_d = S_UPD;
      S_UPD:  state_d = S_OUT;
      S_OUT:  if (out_if.ready) state_d = (idx_q == NW'(NEURONS-1)) ? S_IDLE : S_UPD;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      idx_q <= '0;
      rate_q <= 24'd655;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NEURONS; k++) begin
        ext_q[k] <= '0;
        y_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (step_rate_we_i) rate_q <= step_rate_i;
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          idx_q <= '0;
          if (in_if.valid && src_ok) begin
            if (cmd.opcode == OP_STATE) y_q[cmd.source_index[NW-1:0]] <= cmd.write_value;
            if (cmd.opcode == OP_INPUT) ext_q[cmd.source_index[NW-1:0]] <= cmd.write_value;
          end
        end
        S_MAC: cnt_q <= cnt_q + CW'(1);
        S_DER: ;
        S_UPD: begin
          y_q[idx_q] <= ny;
          res_q.neuron_index <= 5'(idx_q);
          res_q.neuron_state <= ny;
          res_q.last_of_run <= (idx_q == NW'(NEURONS-1));
          out_valid_q <= 1'b1;
        end
        S_OUT: if (out_if.ready) begin
          out_valid_q <= 1'b0;
          idx_q <= idx_q + NW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_if.valid && src_ok) begin
      if (cmd.opcode == OP_BIAS) bias_q[cmd.source_index[NW-1:0]] <= cmd.write_value;
    end
    if (state_q == S_DER) begin
      for (int k = 0; k < NEURONS; k++)
        der_q[k] <= sat24((acc[k] + ((48'(ext_q[k]) - 48'(y_q[k])) <<< 16)) >>> 16);
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && out_if.payload.last_of_run |=> in_if.ready)
    else $error("no return to idle");
endmodule
